FILE: sv/nalsplit_pkg.sv
// Package for the Annex B NAL unit splitter.
// Holds widths, start-code constants and the result beat type.
// No dependencies.
package nalsplit_pkg;

  localparam int unsigned LengthBits = 20;
  localparam int unsigned UnitLengthWidth = 20;
  localparam int unsigned TypeWidth = 5;
  localparam int unsigned ResultWidth = TypeWidth + UnitLengthWidth + 2;
  localparam int unsigned MDataWidth = ((ResultWidth + 7) / 8) * 8;

  localparam logic [7:0] StartZero = 8'h00;
  localparam logic [7:0] StartOne = 8'h01;
  localparam logic [7:0] TypeMask = 8'h1f;
  localparam logic [23:0] WindowReset = 24'hFFFFFF;
  localparam logic [1:0] WindowFull = 2'd3;

  typedef logic [LengthBits-1:0] count_t;
  typedef logic [LengthBits:0] len_sum_t;

  localparam count_t CountMax = '1;

  // Lowest bits first: unit_type, unit_length, length_saturated, ended_by_buffer.
  typedef struct packed {
    logic                       ended_by_buffer;
    logic                       length_saturated;
    logic [UnitLengthWidth-1:0] unit_length;
    logic [TypeWidth-1:0]       unit_type;
  } result_t;

endpackage

FILE: sv/nalsplit_parser.sv
// Start-code search window, unit state and result formation.
// Depends on nalsplit_pkg.
module nalsplit_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  beat_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  output logic                  res_valid_o,
  output nalsplit_pkg::result_t res_o
);

  logic [23:0]                    recent_q, recent_d;
  logic                           inside_q, inside_d;
  logic                           have_hdr_q, have_hdr_d;
  logic [nalsplit_pkg::TypeWidth-1:0] type_q, type_d;
  nalsplit_pkg::count_t           count_q, count_d;
  logic                           ovf_q, ovf_d;
  logic [1:0]                     fill_q, fill_d;

  logic                           start;
  logic [7:0]                     hdr_bits;
  nalsplit_pkg::len_sum_t         len_sum;
  logic                           sat;
  nalsplit_pkg::len_sum_t         len_clamped;

  assign start = (recent_q == {3{nalsplit_pkg::StartZero}}) && (byte_i == nalsplit_pkg::StartOne);
  assign hdr_bits = byte_i & nalsplit_pkg::TypeMask;

  always_comb begin
    recent_d = recent_q;
    inside_d = inside_q;
    have_hdr_d = have_hdr_q;
    type_d = type_q;
    count_d = count_q;
    ovf_d = ovf_q;
    fill_d = fill_q;
    res_valid_o = 1'b0;
    len_sum = {1'b0, count_q};
    sat = ovf_q;
    res_o.ended_by_buffer = 1'b0;
    res_o.unit_type = type_q;

    if (beat_i) begin
      recent_d = {recent_q[15:0], byte_i};
      if (start) begin
        res_valid_o = inside_q && ((count_q != '0) || ovf_q);
        inside_d = 1'b1;
        have_hdr_d = 1'b0;
        type_d = '0;
        count_d = '0;
        ovf_d = 1'b0;
        fill_d = '0;
      end else if (inside_q) begin
        if (!have_hdr_q) begin
          have_hdr_d = 1'b1;
          type_d = hdr_bits[nalsplit_pkg::TypeWidth-1:0];
        end
        if (fill_q == nalsplit_pkg::WindowFull) begin
          if (count_q == nalsplit_pkg::CountMax) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + 1'b1;
          end
        end else begin
          fill_d = fill_q + 2'd1;
        end
        if (last_i) begin
          res_valid_o = 1'b1;
          res_o.ended_by_buffer = 1'b1;
          res_o.unit_type = type_d;
          len_sum = {1'b0, count_d} + nalsplit_pkg::len_sum_t'(fill_d);
          sat = ovf_d;
        end
      end
      if (last_i) begin
        recent_d = nalsplit_pkg::WindowReset;
        inside_d = 1'b0;
        have_hdr_d = 1'b0;
        type_d = '0;
        count_d = '0;
        ovf_d = 1'b0;
        fill_d = '0;
      end
    end

    res_o.length_saturated = sat || len_sum[nalsplit_pkg::LengthBits];
    len_clamped = res_o.length_saturated ? {1'b0, nalsplit_pkg::CountMax} : len_sum;
    res_o.unit_length = nalsplit_pkg::UnitLengthWidth'(len_clamped);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= nalsplit_pkg::WindowReset;
      inside_q <= 1'b0;
      have_hdr_q <= 1'b0;
      type_q <= '0;
      count_q <= '0;
      ovf_q <= 1'b0;
      fill_q <= '0;
    end else begin
      recent_q <= recent_d;
      inside_q <= inside_d;
      have_hdr_q <= have_hdr_d;
      type_q <= type_d;
      count_q <= count_d;
      ovf_q <= ovf_d;
      fill_q <= fill_d;
    end
  end

  a_hdr_in_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_hdr_q |-> inside_q)
    else $error("header flag set outside a unit");

  a_count_after_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != nalsplit_pkg::WindowFull) |-> ((count_q == '0) && !ovf_q))
    else $error("byte count advanced before window filled");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_i && last_i) |=> ((recent_q == nalsplit_pkg::WindowReset) && !inside_q))
    else $error("state not cleared after buffer end");

endmodule

FILE: sv/nalsplit_out_buf.sv
// Result register with one skid entry on the master side.
// Depends on nalsplit_pkg.
module nalsplit_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  nalsplit_pkg::result_t push_data_i,
  output logic                  can_push_o,
  output logic                  out_valid_o,
  output nalsplit_pkg::result_t out_data_o,
  input  logic                  out_ready_i
);

  logic                  out_valid_q, out_valid_d;
  logic                  skid_valid_q, skid_valid_d;
  nalsplit_pkg::result_t out_q, out_d;
  nalsplit_pkg::result_t skid_q, skid_d;
  logic                  take;

  assign take = out_valid_q && out_ready_i;
  assign can_push_o = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d = out_q;
    skid_d = skid_q;
    if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_d = skid_q;
        out_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d = push_data_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    skid_q <= skid_d;
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while result register empty");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("push into full buffer");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && take) |=> (out_valid_q && !skid_valid_q && (out_q == $past(skid_q))))
    else $error("skid entry lost on drain");

endmodule

FILE: sv/nal_unit_start_code_splitter.sv
// Top level of the Annex B NAL unit splitter.
// Depends on nalsplit_pkg, nalsplit_parser and nalsplit_out_buf.
//
// Takes one stream byte per clock on the slave side (tlast marks the last byte of a
// buffer) and searches for 00 00 00 01 at every byte position. Each NAL unit closed by
// the next start code or by the buffer end gives one beat on the master side through
// the result register; empty units and bytes before the first start code give
// nothing. Throughput is one byte per cycle while s_axis_tready_o is high: the
// start-code window and the length counter update in the cycle the byte is
// accepted. The master side has a result register plus one skid entry, so
// s_axis_tready_o drops only while both hold a result the sink has not yet taken.
// Lengths count the header byte and clamp to all ones with length_saturated set.
module nal_unit_start_code_splitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // buffer_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [4:0] unit_type, [24:5] unit_length, [25] length_saturated,
  // [26] ended_by_buffer, [31:27] zero
  output logic [nalsplit_pkg::MDataWidth-1:0] m_axis_tdata_o
);

  logic                  beat;
  logic                  res_valid;
  logic                  can_push;
  nalsplit_pkg::result_t res;
  nalsplit_pkg::result_t out_res;

  assign s_axis_tready_o = can_push;
  assign beat = s_axis_tvalid_i && can_push;

  nalsplit_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .byte_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  nalsplit_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .can_push_o  (can_push),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (out_res),
    .out_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = nalsplit_pkg::MDataWidth'(out_res);

endmodule
